[hdl/lfpd_pkg.sv]
// Shared types, codes and constants of the length-framed packet decoder.
`default_nettype none

package lfpd_pkg;

    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int STORE_DEPTH_DEF = 256;

    localparam logic [BYTE_W-1:0] HEAD_BYTE_RST   = 8'd170;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST   = 8'd85;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd255;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_RESYNC = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD = 2'd0,
        CFG_TAIL = 2'd1,
        CFG_MAX  = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING  = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_LEN_ERR  = 3'd3,
        ST_SUM_ERR  = 3'd4,
        ST_TAIL_ERR = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_LEN     = 3'd1,
        PH_LEN_INV = 3'd2,
        PH_DATA    = 3'd3,
        PH_SUM     = 3'd4,
        PH_TAIL    = 3'd5
    } t_phase;

    // Per-item decode result handed from the frame FSM to the top level.
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] flen;
        logic              hunting;
    } t_dec_res;

    // Payload store write request.
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] pos;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

endpackage

`default_nettype wire

[hdl/lfpd_if.sv]
// Valid/ready channel interfaces: input item, result item and config write.
`default_nettype none

interface lfpd_item_if import lfpd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   byte_in;
    logic [BYTE_W-1:0]   read_index;

    modport source (output valid, output kind, output byte_in, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input byte_in, input read_index,
                    output ready);
endinterface

interface lfpd_result_if import lfpd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_length;
    logic [BYTE_W-1:0]   read_data;

    modport source (output valid, output status, output frame_length, output read_data,
                    input ready);
    modport sink   (input valid, input status, input frame_length, input read_data,
                    output ready);
endinterface

interface lfpd_cfg_if import lfpd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/length_framed_packet_decoder_core.sv]
// Top level of the length-framed packet decoder: config, pipeline and payload store.
//
// Decodes a byte stream framed as head, length L, ~L, L payload bytes, additive
// checksum (L plus payload, mod 256) and tail. Every item gets exactly one result:
// byte items report pending, complete (with the frame length), overflow, length
// error, checksum error or tail error, and any error drops back to head hunting;
// read items return the stored payload byte at read_index (zero beyond the store);
// resync items clear the decoder but keep the store. The block takes one item per
// clock cycle while the result channel does not stall; a result passes through stage 1
// (decoder update and registered store read) and then the output register. The
// decoder state turns over once for each accepted byte, and the store has one
// write port and one registered read port, so byte writes and read items never
// compete. The payload store has no reset: reading an entry that no frame has
// written returns whatever the RAM holds. Config registers (head, tail, max
// payload) are written through the config channel, which is always ready and
// must only be used while the decoder is idle.
`default_nettype none

module length_framed_packet_decoder_core import lfpd_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lfpd_cfg_if.sink      i_cfg,
    lfpd_item_if.sink     i_in,
    lfpd_result_if.source o_out
);

    localparam int              AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [BYTE_W:0] RD_LIMIT = (BYTE_W+1)'(STORE_DEPTH);

    // Config registers
    logic [BYTE_W-1:0] r_head_byte, r_tail_byte, r_max_payload;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte   <= HEAD_BYTE_RST;
            r_tail_byte   <= TAIL_BYTE_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_HEAD: r_head_byte   <= i_cfg.data;
                CFG_TAIL: r_tail_byte   <= i_cfg.data;
                CFG_MAX:  r_max_payload <= i_cfg.data;
                default:  ;  // unused index: write ignored
            endcase
        end
    end

    // Handshake: stage 1 holds the decoded item while the store read completes,
    // the output register holds the finished result.
    logic    r_s1_v, r_o_v;
    logic    s1_adv, in_acc;
    logic    is_byte, is_read, is_resync, rd_in_range;

    assign s1_adv     = r_s1_v && (!r_o_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign is_byte     = (t_kind'(i_in.kind) == KIND_BYTE);
    assign is_read     = (t_kind'(i_in.kind) == KIND_READ);
    assign is_resync   = (t_kind'(i_in.kind) == KIND_RESYNC);
    assign rd_in_range = ({1'b0, i_in.read_index} < RD_LIMIT);

    // Frame decoder
    t_dec_res  dec;
    t_store_wr wr;

    lfpd_frame_fsm #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (in_acc && is_byte),
        .i_resync      (in_acc && is_resync),
        .i_byte        (i_in.byte_in),
        .i_head_byte   (r_head_byte),
        .i_tail_byte   (r_tail_byte),
        .i_max_payload (r_max_payload),
        .o_res         (dec),
        .o_wr          (wr)
    );

    // Payload store. Read data is only refreshed on an accepted read item, so
    // it stays put while stage 1 is stalled.
    logic              rd_en;
    logic [BYTE_W-1:0] ram_q;

    assign rd_en = in_acc && is_read && rd_in_range;

    lfpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.pos[AW-1:0]),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_in.read_index[AW-1:0]),
        .o_rd_data (ram_q)
    );

    // Stage 1
    t_status           r_s1_status;
    logic [BYTE_W-1:0] r_s1_flen;
    logic              r_s1_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= dec.status;
            r_s1_flen   <= dec.flen;
            r_s1_rd     <= is_read && rd_in_range;
        end
    end

    // Output register
    t_status           r_o_status;
    logic [BYTE_W-1:0] r_o_flen;
    logic [BYTE_W-1:0] r_o_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_adv) begin
            r_o_v <= 1'b1;
        end else if (o_out.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_status <= r_s1_status;
            r_o_flen   <= r_s1_flen;
            r_o_rdata  <= r_s1_rd ? ram_q : '0;
        end
    end

    assign o_out.valid        = r_o_v;
    assign o_out.status       = r_o_status;
    assign o_out.frame_length = r_o_flen;
    assign o_out.read_data    = r_o_rdata;

    // Checks
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_adv) |=> (r_s1_v && $stable(r_s1_status) && $stable(r_s1_flen)))
        else $error("stage 1 item lost or changed while stalled");

    a_wr_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (in_acc && is_byte && !rd_en))
        else $error("store write without an accepted byte item");

    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_byte && (dec.status != ST_PENDING)) |=> dec.hunting)
        else $error("decoder not back to head hunting after frame end");

endmodule

`default_nettype wire

[hdl/lfpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/lfpd_frame_fsm.sv]
// Frame decoder state machine: phase, length, write position, running checksum.
`default_nettype none

module lfpd_frame_fsm import lfpd_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic              i_resync,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_head_byte,
    input  wire logic [BYTE_W-1:0] i_tail_byte,
    input  wire logic [BYTE_W-1:0] i_max_payload,
    output t_dec_res               o_res,
    output t_store_wr              o_wr
);

    localparam logic [BYTE_W:0] DEPTH_LIM = (BYTE_W+1)'(STORE_DEPTH);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_wpos, n_wpos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] wpos_inc;
    logic              clr;

    assign wpos_inc = r_wpos + 1'b1;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_wpos  = r_wpos;
        n_sum   = r_sum;
        clr     = i_resync;
        if (i_take) begin
            case (r_phase)
                PH_HEAD: begin
                    if (i_byte == i_head_byte) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len  = i_byte;
                    n_wpos = '0;
                    n_sum  = i_byte;
                    if (i_byte > i_max_payload) clr = 1'b1;
                    else                        n_phase = PH_LEN_INV;
                end
                PH_LEN_INV: begin
                    if (i_byte != ~r_len)  clr = 1'b1;
                    else if (r_len == '0)  n_phase = PH_SUM;
                    else                   n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_sum  = r_sum + i_byte;
                    n_wpos = wpos_inc;
                    if (wpos_inc >= r_len) n_phase = PH_SUM;
                end
                PH_SUM: begin
                    if (i_byte != r_sum) clr = 1'b1;
                    else                 n_phase = PH_TAIL;
                end
                PH_TAIL: begin
                    clr = 1'b1;
                end
                default: begin
                    clr = 1'b1;
                end
            endcase
        end
        if (clr) begin
            n_phase = PH_HEAD;
            n_len   = '0;
            n_wpos  = '0;
            n_sum   = '0;
        end
    end

    // Outputs
    always_comb begin
        o_res.status  = ST_PENDING;
        o_res.flen    = '0;
        o_res.hunting = (r_phase == PH_HEAD);
        o_wr.en       = 1'b0;
        o_wr.pos      = r_wpos;
        o_wr.data     = i_byte;
        if (i_take) begin
            case (r_phase)
                PH_LEN: begin
                    if (i_byte > i_max_payload) o_res.status = ST_OVERFLOW;
                end
                PH_LEN_INV: begin
                    if (i_byte != ~r_len) o_res.status = ST_LEN_ERR;
                end
                PH_DATA: begin
                    o_wr.en = ({1'b0, r_wpos} < DEPTH_LIM);
                end
                PH_SUM: begin
                    if (i_byte != r_sum) o_res.status = ST_SUM_ERR;
                end
                PH_TAIL: begin
                    if (i_byte != i_tail_byte) begin
                        o_res.status = ST_TAIL_ERR;
                    end else begin
                        o_res.status = ST_COMPLETE;
                        o_res.flen   = r_len;
                    end
                end
                default: begin
                    o_res.status = ST_PENDING;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_len   <= '0;
            r_wpos  <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_wpos  <= n_wpos;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire
